// File: sv/fgr_pkg.sv
// Shared types, constants and the 5x7 font table of the glyph rasterizer.
package fgr_pkg;

    localparam int GLYPH_COLS          = 5;
    localparam int GLYPH_ROWS          = 8;
    localparam int GLYPH_BITS          = GLYPH_COLS * GLYPH_ROWS;
    localparam int DEF_SCREEN_WIDTH    = 320;
    localparam int DEF_SCREEN_HEIGHT   = 240;
    localparam logic [15:0] CHAR_ADVANCE = 16'd6;

    typedef logic [GLYPH_BITS-1:0] glyph_t;

    // One walk step handed from the walker to the output buffer.
    typedef struct packed {
        logic        flush;
        logic        visible;
        logic [8:0]  x;
        logic [7:0]  y;
        logic [15:0] color;
    } step_t;

    // Column 0 sits in the low byte, and within a column row 0 is the low bit.
    function automatic glyph_t glyph_bits(input logic [7:0] ch);
        glyph_t g;
        unique case (ch)
            8'h2E: g = {8'h00, 8'h00, 8'h24, 8'h00, 8'h00};
            8'h30: g = {8'h3E, 8'h45, 8'h49, 8'h51, 8'h3E};
            8'h31: g = {8'h00, 8'h40, 8'h7F, 8'h42, 8'h00};
            8'h32: g = {8'h46, 8'h49, 8'h51, 8'h61, 8'h42};
            8'h33: g = {8'h31, 8'h4B, 8'h45, 8'h41, 8'h21};
            8'h34: g = {8'h10, 8'h7F, 8'h12, 8'h14, 8'h18};
            8'h35: g = {8'h39, 8'h45, 8'h45, 8'h45, 8'h27};
            8'h36: g = {8'h30, 8'h49, 8'h49, 8'h4A, 8'h3C};
            8'h37: g = {8'h03, 8'h05, 8'h09, 8'h71, 8'h01};
            8'h38: g = {8'h36, 8'h49, 8'h49, 8'h49, 8'h36};
            8'h39: g = {8'h1E, 8'h29, 8'h49, 8'h49, 8'h06};
            8'h3A: g = {8'h00, 8'h00, 8'h36, 8'h36, 8'h00};
            8'h43: g = {8'h14, 8'h22, 8'h41, 8'h41, 8'h3E};
            8'h46: g = {8'h01, 8'h09, 8'h09, 8'h09, 8'h7F};
            8'h4C: g = {8'h40, 8'h40, 8'h40, 8'h40, 8'h7F};
            8'h48: g = {8'h7F, 8'h02, 8'h04, 8'h02, 8'h7F};
            8'h4F: g = {8'h22, 8'h41, 8'h41, 8'h41, 8'h3E};
            8'h50: g = {8'h06, 8'h09, 8'h09, 8'h09, 8'h7F};
            8'h56: g = {8'h5F, 8'h20, 8'h40, 8'h40, 8'h3F};
            8'h61: g = {8'h7C, 8'h12, 8'h11, 8'h12, 8'h7C};
            8'h6D: g = {8'h78, 8'h54, 8'h54, 8'h54, 8'h20};
            8'h70: g = {8'h08, 8'h14, 8'h14, 8'h14, 8'h7C};
            8'h75: g = {8'h44, 8'h7C, 8'h04, 8'h3C, 8'h44};
            8'h7A: g = {8'h20, 8'h54, 8'h54, 8'h54, 8'h48};
            default: g = '0;
        endcase
        return g;
    endfunction

endpackage

// File: sv/fgr_walker.sv
// Glyph walker: shifts the cell bitmap out one bit per step and tracks the pixel position.
module fgr_walker #(
    parameter int SCREEN_WIDTH  = fgr_pkg::DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = fgr_pkg::DEF_SCREEN_HEIGHT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [7:0]           char_code,
    input  logic [15:0]          cursor,
    input  logic [15:0]          start_y,
    input  logic [15:0]          fg_color,
    input  logic [15:0]          bg_color,
    output logic                 busy,
    output logic                 step_valid,
    output fgr_pkg::step_t       step,
    input  logic                 step_ready
);

    localparam logic [16:0] WIDTH_LIM  = 17'(SCREEN_WIDTH);
    localparam logic [16:0] HEIGHT_LIM = 17'(SCREEN_HEIGHT);
    localparam logic [2:0]  LAST_COL   = 3'(fgr_pkg::GLYPH_COLS - 1);
    localparam logic [2:0]  LAST_ROW   = 3'(fgr_pkg::GLYPH_ROWS - 1);

    typedef enum logic [1:0] {IDLE, WALK, FLUSH} state_t;

    state_t            state_reg, state_next;
    fgr_pkg::glyph_t   glyph_reg, glyph_next;
    logic [2:0]        col_reg, col_next;
    logic [2:0]        row_reg, row_next;
    logic [15:0]       x_reg, x_next;
    logic [15:0]       y_reg, y_next;
    logic [15:0]       ybase_reg, ybase_next;
    logic [15:0]       fg_reg, fg_next;
    logic [15:0]       bg_reg, bg_next;
    logic              on_screen;
    logic              drawn;

    assign on_screen = ({1'b0, x_reg} < WIDTH_LIM) && ({1'b0, y_reg} < HEIGHT_LIM);
    assign drawn     = glyph_reg[0] || (bg_reg != fg_reg);

    assign busy       = (state_reg != IDLE);
    assign step_valid = busy;

    always_comb
    begin
        step.flush   = (state_reg == FLUSH);
        step.visible = (state_reg == WALK) && drawn && on_screen;
        step.x       = x_reg[8:0];
        step.y       = y_reg[7:0];
        step.color   = glyph_reg[0] ? fg_reg : bg_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        glyph_next = glyph_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        ybase_next = ybase_reg;
        fg_next    = fg_reg;
        bg_next    = bg_reg;
        unique case (state_reg)
            IDLE:
            begin
                if (start)
                begin
                    state_next = WALK;
                    glyph_next = fgr_pkg::glyph_bits(char_code);
                    col_next   = '0;
                    row_next   = '0;
                    x_next     = cursor;
                    y_next     = start_y;
                    ybase_next = start_y;
                    fg_next    = fg_color;
                    bg_next    = bg_color;
                end
            end
            WALK:
            begin
                if (step_ready)
                begin
                    glyph_next = glyph_reg >> 1;
                    if (row_reg == LAST_ROW)
                    begin
                        row_next = '0;
                        y_next   = ybase_reg;
                        col_next = col_reg + 3'd1;
                        x_next   = x_reg + 16'd1;
                        if (col_reg == LAST_COL)
                        begin
                            state_next = FLUSH;
                        end
                    end
                    else
                    begin
                        row_next = row_reg + 3'd1;
                        y_next   = y_reg + 16'd1;
                    end
                end
            end
            FLUSH:
            begin
                if (step_ready)
                begin
                    state_next = IDLE;
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        glyph_reg <= glyph_next;
        col_reg   <= col_next;
        row_reg   <= row_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
        ybase_reg <= ybase_next;
        fg_reg    <= fg_next;
        bg_reg    <= bg_next;
    end

endmodule

// File: sv/fgr_outbuf.sv
// Output buffer: holds one pixel back so that the final pixel of a character can be marked.
module fgr_outbuf (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step_valid,
    input  fgr_pkg::step_t       step,
    output logic                 step_ready,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [8:0]           pixel_x,
    output logic [7:0]           pixel_y,
    output logic [15:0]          pixel_color,
    output logic                 last_pixel
);

    logic          pend_valid_reg, pend_valid_next;
    logic [8:0]    pend_x_reg, pend_x_next;
    logic [7:0]    pend_y_reg, pend_y_next;
    logic [15:0]   pend_color_reg, pend_color_next;
    logic          out_valid_reg, out_valid_next;
    logic [8:0]    out_x_reg, out_x_next;
    logic [7:0]    out_y_reg, out_y_next;
    logic [15:0]   out_color_reg, out_color_next;
    logic          out_last_reg, out_last_next;
    logic          take;

    assign step_ready = !out_valid_reg || !out_stall;
    assign take       = step_valid && step_ready;

    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        pend_x_next     = pend_x_reg;
        pend_y_next     = pend_y_reg;
        pend_color_next = pend_color_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_x_next      = out_x_reg;
        out_y_next      = out_y_reg;
        out_color_next  = out_color_reg;
        out_last_next   = out_last_reg;
        if (take && (step.flush || step.visible) && pend_valid_reg)
        begin
            out_valid_next = 1'b1;
            out_x_next     = pend_x_reg;
            out_y_next     = pend_y_reg;
            out_color_next = pend_color_reg;
            out_last_next  = step.flush;
        end
        if (take && step.flush)
        begin
            pend_valid_next = 1'b0;
        end
        else if (take && step.visible)
        begin
            pend_valid_next = 1'b1;
            pend_x_next     = step.x;
            pend_y_next     = step.y;
            pend_color_next = step.color;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_x_reg     <= pend_x_next;
        pend_y_reg     <= pend_y_next;
        pend_color_reg <= pend_color_next;
        out_x_reg      <= out_x_next;
        out_y_reg      <= out_y_next;
        out_color_reg  <= out_color_next;
        out_last_reg   <= out_last_next;
    end

    assign out_valid   = out_valid_reg;
    assign pixel_x     = out_x_reg;
    assign pixel_y     = out_y_reg;
    assign pixel_color = out_color_reg;
    assign last_pixel  = out_last_reg;

    a_flush_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (take && step.flush) |=> !pend_valid_reg)
        else $error("pending pixel survived the end of a character");

    a_visible_held: assert property (@(posedge clk) disable iff (!rst_n)
        (take && !step.flush && step.visible) |=> pend_valid_reg)
        else $error("visible pixel was not held back");

    a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
        !step_ready |=> $stable(pend_valid_reg) && $stable(pend_x_reg) && $stable(pend_y_reg))
        else $error("pending pixel changed while the output was blocked");

    a_last_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (take && step.flush && pend_valid_reg) |=> out_valid_reg && out_last_reg)
        else $error("final pixel was not marked");

endmodule

// File: sv/font_glyph_pixel_rasterizer.sv
// Top level of the 5x7 bitmap font pixel rasterizer.
//
//  Channel  | Direction | Handshake          | Payload
//  ---------+-----------+--------------------+---------------------------------------------
//  input    | in        | in_valid/in_stall  | char_code new_string start_x start_y
//           |           |                    | fg_color bg_color
//  output   | out       | out_valid/out_stall| pixel_x pixel_y pixel_color last_pixel
//
// After a character request is taken the walker stays busy for 40 walk steps, one per
// glyph bit as the cell bitmap is shifted out of the walker's shift register, and one step
// that releases the held-back final pixel with its last mark. The walker then returns to
// idle, so a request is not taken before the previous character is walked out. A step
// waits while out_stall is high and the output register is full.
// A new request is taken as soon as the walker is idle again, even while the final pixel
// of the previous character still waits in the output register.
// Reset (rst_n, asynchronous, active low) clears the cursor to zero and empties both
// the walker and the output buffer.
module font_glyph_pixel_rasterizer #(
    parameter int SCREEN_WIDTH  = fgr_pkg::DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = fgr_pkg::DEF_SCREEN_HEIGHT
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_stall,
    input  logic [7:0]   char_code,
    input  logic         new_string,
    input  logic [15:0]  start_x,
    input  logic [15:0]  start_y,
    input  logic [15:0]  fg_color,
    input  logic [15:0]  bg_color,
    output logic         out_valid,
    input  logic         out_stall,
    output logic [8:0]   pixel_x,
    output logic [7:0]   pixel_y,
    output logic [15:0]  pixel_color,
    output logic         last_pixel
);

    logic [15:0]      cursor_reg, cursor_next;
    logic             busy;
    logic             accept;
    logic             step_valid;
    logic             step_ready;
    fgr_pkg::step_t   step;

    // The walker is the only thing that blocks a request.
    assign in_stall = busy;
    assign accept   = in_valid && !busy;

    // The cursor is loaded on the first character of a string and moves one cell to the
    // right on each later character, wrapping at the top of its 16-bit range.
    always_comb
    begin
        cursor_next = cursor_reg;
        if (accept)
        begin
            cursor_next = new_string ? start_x : cursor_reg + fgr_pkg::CHAR_ADVANCE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_reg <= '0;
        end
        else
        begin
            cursor_reg <= cursor_next;
        end
    end

    // The walker sees the updated cursor in the same cycle that the request is taken.
    fgr_walker #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_walker (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (accept),
        .char_code  (char_code),
        .cursor     (cursor_next),
        .start_y    (start_y),
        .fg_color   (fg_color),
        .bg_color   (bg_color),
        .busy       (busy),
        .step_valid (step_valid),
        .step       (step),
        .step_ready (step_ready)
    );

    // The buffer keeps one pixel in hand, so the final drawn pixel is known only when
    // the walk is over; a character with nothing drawn produces no output at all.
    fgr_outbuf u_outbuf (
        .clk         (clk),
        .rst_n       (rst_n),
        .step_valid  (step_valid),
        .step        (step),
        .step_ready  (step_ready),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .pixel_color (pixel_color),
        .last_pixel  (last_pixel)
    );

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("walker did not start on an accepted request");

    a_cursor_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(cursor_reg))
        else $error("cursor moved without a request");

    a_no_step_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !busy |-> !step_valid)
        else $error("walk step offered while the walker is idle");

endmodule

// File: tb/sv/glyph_pixel_checker.sv
// Checker for the glyph rasterizer: predicts the pixels of each request and compares the output.
`timescale 1ns / 100ps

module glyph_pixel_checker #(
    parameter int SCREEN_WIDTH  = fgr_pkg::DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = fgr_pkg::DEF_SCREEN_HEIGHT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [7:0]  char_code,
    input  logic        new_string,
    input  logic [15:0] start_x,
    input  logic [15:0] start_y,
    input  logic [15:0] fg_color,
    input  logic [15:0] bg_color,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [8:0]  pixel_x,
    input  logic [7:0]  pixel_y,
    input  logic [15:0] pixel_color,
    input  logic        last_pixel,
    output int          mismatches,
    output int          outstanding
);

    // Column bytes of one glyph, leftmost column at index 0, top row in bit 0.
    typedef logic [0:fgr_pkg::GLYPH_COLS-1][7:0] glyph_cols_t;

    typedef struct packed {
        logic [8:0]  x;
        logic [7:0]  y;
        logic [15:0] color;
        logic        last;
    } pixel_t;

    pixel_t      pending_pixels[$];
    logic [15:0] cursor_x;

    function automatic glyph_cols_t font_cols(input logic [7:0] ch);
        case (ch)
            "0":     return {8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E};
            "1":     return {8'h00, 8'h42, 8'h7F, 8'h40, 8'h00};
            "2":     return {8'h42, 8'h61, 8'h51, 8'h49, 8'h46};
            "3":     return {8'h21, 8'h41, 8'h45, 8'h4B, 8'h31};
            "4":     return {8'h18, 8'h14, 8'h12, 8'h7F, 8'h10};
            "5":     return {8'h27, 8'h45, 8'h45, 8'h45, 8'h39};
            "6":     return {8'h3C, 8'h4A, 8'h49, 8'h49, 8'h30};
            "7":     return {8'h01, 8'h71, 8'h09, 8'h05, 8'h03};
            "8":     return {8'h36, 8'h49, 8'h49, 8'h49, 8'h36};
            "9":     return {8'h06, 8'h49, 8'h49, 8'h29, 8'h1E};
            ".":     return {8'h00, 8'h00, 8'h24, 8'h00, 8'h00};
            ":":     return {8'h00, 8'h36, 8'h36, 8'h00, 8'h00};
            "C":     return {8'h3E, 8'h41, 8'h41, 8'h22, 8'h14};
            "F":     return {8'h7F, 8'h09, 8'h09, 8'h09, 8'h01};
            "L":     return {8'h7F, 8'h40, 8'h40, 8'h40, 8'h40};
            "H":     return {8'h7F, 8'h02, 8'h04, 8'h02, 8'h7F};
            "O":     return {8'h3E, 8'h41, 8'h41, 8'h41, 8'h22};
            "P":     return {8'h7F, 8'h09, 8'h09, 8'h09, 8'h06};
            "V":     return {8'h3F, 8'h40, 8'h40, 8'h20, 8'h5F};
            "a":     return {8'h7C, 8'h12, 8'h11, 8'h12, 8'h7C};
            "m":     return {8'h20, 8'h54, 8'h54, 8'h54, 8'h78};
            "p":     return {8'h7C, 8'h14, 8'h14, 8'h14, 8'h08};
            "u":     return {8'h44, 8'h3C, 8'h04, 8'h7C, 8'h44};
            "z":     return {8'h48, 8'h54, 8'h54, 8'h54, 8'h20};
            default: return '0;
        endcase
    endfunction

    // Walks the cell column by column, rows upward from bit 0, and queues the visible pixels.
    task automatic rasterize_char(input logic [7:0] ch, input logic [15:0] row0,
                                  input logic [15:0] fg, input logic [15:0] bg);
        glyph_cols_t cols;
        pixel_t      drawn[fgr_pkg::GLYPH_BITS];
        int          n;
        logic [15:0] px;
        logic [15:0] py;
        logic        painted;
        logic [15:0] colour;
        cols = font_cols(ch);
        n = 0;
        for (int col = 0; col < fgr_pkg::GLYPH_COLS; col++) begin
            for (int row = 0; row < fgr_pkg::GLYPH_ROWS; row++) begin
                px = cursor_x + col[15:0];
                py = row0 + row[15:0];
                painted = cols[col][row] || (bg != fg);
                colour = cols[col][row] ? fg : bg;
                if (painted && px < SCREEN_WIDTH && py < SCREEN_HEIGHT) begin
                    drawn[n] = '{x: px[8:0], y: py[7:0], color: colour, last: 1'b0};
                    n++;
                end
            end
        end
        for (int i = 0; i < n; i++) begin
            if (i == n - 1)
                drawn[i].last = 1'b1;
            pending_pixels.push_back(drawn[i]);
        end
    endtask

    initial
    begin
        mismatches = 0;
        outstanding = 0;
        cursor_x = '0;
    end

    always @(posedge clk or negedge rst_n)
    begin : watch_channels
        pixel_t want;
        if (!rst_n)
        begin
            cursor_x = '0;
            pending_pixels.delete();
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                cursor_x = new_string ? start_x : cursor_x + fgr_pkg::CHAR_ADVANCE;
                rasterize_char(char_code, start_y, fg_color, bg_color);
            end
            if (out_valid && !out_stall)
            begin
                if (pending_pixels.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected pixel x=%0d y=%0d color=%h last=%b",
                                 $time, pixel_x, pixel_y, pixel_color, last_pixel);
                end
                else
                begin
                    want = pending_pixels.pop_front();
                    if (pixel_x !== want.x || pixel_y !== want.y ||
                        pixel_color !== want.color || last_pixel !== want.last)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"%0t: pixel mismatch: expected x=%0d y=%0d color=%h ",
                                      "last=%b, got x=%0d y=%0d color=%h last=%b"},
                                     $time, want.x, want.y, want.color, want.last,
                                     pixel_x, pixel_y, pixel_color, last_pixel);
                    end
                end
            end
        end
        outstanding = pending_pixels.size();
    end

endmodule

// File: tb/sv/tb_font_glyph_pixel_rasterizer.sv
// Testbench top for the glyph rasterizer: clock, reset, request stimulus and the verdict.
`timescale 1ns / 100ps

module tb_font_glyph_pixel_rasterizer;

    // Total character requests, directed part included.
    localparam int REQUEST_TARGET = 420;
    // Length of the one long receiver hold-off that forces the block to back up.
    localparam int HOLD_CYCLES    = 300;
    // Cycles without any accepted request or pixel before the run is declared hung.
    localparam int IDLE_LIMIT     = 3000;
    // Drain time after the last expected pixel: one full character walk and some margin.
    localparam int TAIL_CYCLES    = 60;
    // Every character that has a glyph in the font.
    localparam logic [8*24-1:0] GLYPH_SET = "0123456789.:CFLHOPVampuz";

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  char_code;
    logic        new_string;
    logic [15:0] start_x;
    logic [15:0] start_y;
    logic [15:0] fg_color;
    logic [15:0] bg_color;
    logic        out_valid;
    logic        out_stall;
    logic [8:0]  pixel_x;
    logic [7:0]  pixel_y;
    logic [15:0] pixel_color;
    logic        last_pixel;

    int mismatches;
    int outstanding;
    int requests_sent;
    int idle_cycles;

    // When quiet is set neither side inserts gaps; hold_off_req asks the receiver for the
    // long stall and is cleared by the receiver once that stall is over.
    bit quiet;
    bit hold_off_req;

    font_glyph_pixel_rasterizer dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .char_code   (char_code),
        .new_string  (new_string),
        .start_x     (start_x),
        .start_y     (start_y),
        .fg_color    (fg_color),
        .bg_color    (bg_color),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .pixel_color (pixel_color),
        .last_pixel  (last_pixel)
    );

    glyph_pixel_checker raster_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .char_code   (char_code),
        .new_string  (new_string),
        .start_x     (start_x),
        .start_y     (start_y),
        .fg_color    (fg_color),
        .bg_color    (bg_color),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .pixel_color (pixel_color),
        .last_pixel  (last_pixel),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Gap lengths for both sides: mostly none, often short, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // Mostly characters of the font, with the occasional arbitrary code, which usually draws blank.
    function automatic logic [7:0] pick_char();
        int k;
        k = $urandom_range(0, 23);
        if ($urandom_range(0, 9) < 8)
            return GLYPH_SET[8*k +: 8];
        else
            return 8'($urandom_range(0, 255));
    endfunction

    // Offers one character request, starting and ending on a falling edge. An optional gap
    // with valid low comes first; then the payload is held steady until the block takes it.
    task automatic offer_char(input logic [7:0] ch, input logic fresh,
                              input logic [15:0] sx, input logic [15:0] sy,
                              input logic [15:0] fg, input logic [15:0] bg);
        int gap;
        gap = quiet ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        char_code  <= ch;
        new_string <= fresh;
        start_x    <= sx;
        start_y    <= sy;
        fg_color   <= fg;
        bg_color   <= bg;
        in_valid   <= 1'b1;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        requests_sent++;
        @(negedge clk);
    endtask

    // Receiver side. Stalls of random length, always released between two stalls, and the single
    // long hold-off on request. The long hold is counted here, in the receiver's own process.
    initial
    begin : receiver
        int n;
        out_stall = 1'b0;
        @(negedge clk);
        forever
        begin
            if (hold_off_req)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_off_req = 1'b0;
            end
            else
            begin
                n = quiet ? 0 : pick_gap();
                if (n > 0)
                begin
                    out_stall <= 1'b1;
                    repeat (n) @(negedge clk);
                end
            end
            out_stall <= 1'b0;
            @(negedge clk);
        end
    end

    // Watchdog: any accepted request or pixel restarts the count of idle cycles.
    initial
    begin : watchdog
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin : stimulus
        int          len;
        logic        fresh;
        logic [15:0] sx;
        logic [15:0] sy;
        logic [15:0] fg;
        logic [15:0] bg;

        rst_n         = 1'b0;
        in_valid      = 1'b0;
        char_code     = '0;
        new_string    = 1'b0;
        start_x       = '0;
        start_y       = '0;
        fg_color      = '0;
        bg_color      = '0;
        quiet         = 1'b0;
        hold_off_req  = 1'b0;
        requests_sent = 0;

        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed part. A full cell at the origin, then an advance of the cursor, with the
        // colours at their extremes and swapped.
        offer_char("0", 1'b1, 16'd0, 16'd0, 16'hFFFF, 16'h0000);
        offer_char("1", 1'b0, 16'd0, 16'd0, 16'h0000, 16'hFFFF);
        // Transparent background: only the set bits of the glyph are drawn.
        offer_char("H", 1'b0, 16'd0, 16'd0, 16'hF800, 16'hF800);
        // Codes without a glyph draw blank: nothing at all when transparent, a solid
        // background block when opaque.
        offer_char(8'hFF, 1'b0, 16'd0, 16'd0, 16'h07E0, 16'h07E0);
        offer_char(8'h00, 1'b0, 16'd0, 16'd8, 16'hF800, 16'h001F);
        offer_char(8'h80, 1'b1, 16'd100, 16'd100, 16'h1234, 16'h1234);
        // A cell that ends exactly on the bottom right corner, then one just past the edge.
        offer_char(".", 1'b1, 16'd315, 16'd232, 16'hFFE0, 16'h0010);
        offer_char(":", 1'b0, 16'd315, 16'd232, 16'hFFE0, 16'h0010);
        // Cells clipped by the right edge and by the bottom edge.
        offer_char("C", 1'b1, 16'd318, 16'd120, 16'h8410, 16'h7BEF);
        offer_char("F", 1'b1, 16'd10, 16'd236, 16'h8410, 16'h7BEF);
        // Column and row arithmetic wrapping round 16 bits back onto the screen.
        offer_char("L", 1'b1, 16'hFFFE, 16'd50, 16'hF81F, 16'h0000);
        offer_char("O", 1'b1, 16'd20, 16'hFFFD, 16'hF81F, 16'h0000);
        offer_char("P", 1'b1, 16'hFFFC, 16'hFFFF, 16'h0001, 16'h8000);
        // The cursor itself wraps: 0xFFFC plus one advance lands on column 2.
        offer_char("V", 1'b0, 16'd0, 16'd200, 16'h0001, 16'h8000);
        offer_char("a", 1'b1, 16'hFFFF, 16'hFFFF, 16'hAAAA, 16'h5555);
        // Cells wholly off screen, to the right and below.
        offer_char("m", 1'b1, 16'd400, 16'd10, 16'h5555, 16'hAAAA);
        offer_char("p", 1'b1, 16'd0, 16'd240, 16'h5555, 16'hAAAA);
        offer_char("u", 1'b1, 16'd300, 16'd0, 16'hC618, 16'h0000);
        offer_char("z", 1'b0, 16'd300, 16'd0, 16'hC618, 16'h0000);
        offer_char("5", 1'b1, 16'd160, 16'd119, 16'h001F, 16'h001F);
        offer_char("9", 1'b0, 16'd160, 16'd119, 16'h001F, 16'hFFFF);

        // Back pressure: the receiver holds off for a long stretch while requests keep
        // coming, so the output register and the walker fill and the input stalls.
        quiet = 1'b1;
        hold_off_req = 1'b1;
        for (int k = 0; k < 5; k++)
            offer_char(pick_char(), k == 0, 16'd40, 16'd60, 16'hFFFF, 16'h2104);
        wait (!hold_off_req);
        quiet = 1'b0;

        // Random strings: usually a fresh start, then a run of advancing characters. A few restarts
        // mid-string and arbitrary codes break the pattern; positions are mostly on screen
        // with some anywhere in the 16-bit range.
        while (requests_sent < REQUEST_TARGET)
        begin
            if ($urandom_range(0, 5) == 0)
                quiet = !quiet;
            if ($urandom_range(0, 3) == 0)
            begin
                sx = 16'($urandom_range(0, 65535));
                sy = 16'($urandom_range(0, 65535));
            end
            else
            begin
                sx = 16'($urandom_range(0, 330));
                sy = 16'($urandom_range(0, 245));
            end
            fg = 16'($urandom_range(0, 65535));
            bg = ($urandom_range(0, 2) == 0) ? fg : 16'($urandom_range(0, 65535));
            len = $urandom_range(1, 12);
            for (int k = 0; k < len; k++)
            begin
                if (k == 0)
                    fresh = ($urandom_range(0, 9) != 0);
                else
                    fresh = ($urandom_range(0, 19) == 0);
                if ($urandom_range(0, 7) == 0)
                    fg = 16'($urandom_range(0, 65535));
                offer_char(pick_char(), fresh, sx, sy, fg, bg);
            end
        end
        in_valid <= 1'b0;

        // Drain: every predicted pixel must arrive, and nothing more may follow it.
        wait (outstanding == 0);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
